// ----- rtl/core/hgq_pkg.sv -----
// ----------------------------------------------------------------------------
// Gray histogram package
// Shared types and constants of the gray-level histogram engine.
// ----------------------------------------------------------------------------
package hgq_pkg;

  // Item operation codes carried on the mode field.
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_PIXEL = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  // Configuration register indexes (byte address bit 2).
  localparam logic [0:0] REG_BAR_SCALE   = 1'b0;
  localparam logic [0:0] REG_CURVE_SCALE = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [7:0] BAR_SCALE_RESET   = 8'd200;
  localparam logic [7:0] CURVE_SCALE_RESET = 8'd255;

  // Running sums saturate at this width.
  localparam int          SUM_W   = 40;
  localparam logic [39:0] SUM_MAX = {40{1'b1}};

  // Product width fed to the divider for the curve height.
  localparam int CURVE_NUM_W = 48;

  // Sequencer states.
  typedef enum logic [9:0] {
    S_CLEAR      = 10'b0000000001,
    S_IDLE       = 10'b0000000010,
    S_PIX        = 10'b0000000100,
    S_SCAN       = 10'b0000001000,
    S_SCAN_END   = 10'b0000010000,
    S_BAR        = 10'b0000100000,
    S_BAR_WAIT   = 10'b0001000000,
    S_CURVE      = 10'b0010000000,
    S_CURVE_WAIT = 10'b0100000000,
    S_OUT        = 10'b1000000000
  } state_t;

  // Divider status back to the sequencer.
  typedef struct packed {
    logic       done;
    logic [7:0] quot;
  } div_stat_t;

endpackage

// ----- rtl/core/hgq_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hgq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/hgq_div.sv -----
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring division, one quotient bit per cycle, quotient clamped to 8 bits.
// ----------------------------------------------------------------------------
module hgq_div #(
  parameter int NUM_W = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NUM_W-1:0]   num,
  input  logic [NUM_W-1:0]   den,
  output hgq_pkg::div_stat_t stat
);

  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] step;
  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [NUM_W-1:0] dvs;

  logic [NUM_W:0]   rem_sh;
  logic [NUM_W:0]   diff;
  logic             fits;

  always_comb begin
    rem_sh = {rem, quo[NUM_W-1]};
    diff   = rem_sh - {1'b0, dvs};
    fits   = (rem_sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        rem  <= '0;
        quo  <= num;
        dvs  <= den;
      end else if (busy) begin
        rem  <= fits ? diff[NUM_W-1:0] : rem_sh[NUM_W-1:0];
        quo  <= {quo[NUM_W-2:0], fits};
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.done = done;
  assign stat.quot = (|quo[NUM_W-1:8]) ? 8'hFF : quo[7:0];

endmodule

// ----- rtl/core/gray_histogram_with_scaled_query.sv -----
// ----------------------------------------------------------------------------
// Gray histogram with scaled query
// Histogram of 8-bit pixels with bar and cumulative curve heights on query.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the request channel (req_valid, req_stall, mode,
// value). A clear beat empties every bin and zeroes the peak and the total.
// A pixel beat adds one to its bin, saturating, and updates peak and total.
// A query beat returns one beat on the response channel with the bin count,
// the sum of all lower bins, the bar height and the cumulative curve height.
// Clear and pixel beats return nothing.
// Timing. The bins live in a single-port-write, registered-read RAM, and the
// block handles one item at a time, holding req_stall high while busy. A
// pixel reads its bin, then increments it and writes it back. A clear writes
// one RAM row per cycle. A query walks the RAM from bin 0 up to the queried
// bin, one row per cycle, then runs a shared bit-serial divider (NUM_W = 48
// by default), once for the bar and once for the curve, but skips the
// division for each height whose divisor is zero, making that height zero.
// Reset. After rst the same clearing sweep runs over all BIN_COUNT bins
// before the first item is taken; the APB registers are writable throughout.
// Back-pressure. The response sits in an output register. While rsp_stall
// holds it, the block still takes clear and pixel beats; a second query
// waits in its last state until the register is free.
// ----------------------------------------------------------------------------
module gray_histogram_with_scaled_query #(
  parameter int BIN_COUNT   = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  value,

  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [31:0] bin_count,
  output logic [39:0] below_sum,
  output logic [7:0]  bar_height,
  output logic [7:0]  curve_height,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW    = $clog2(BIN_COUNT);
  localparam int CW    = COUNT_WIDTH;
  localparam int SW    = hgq_pkg::SUM_W;
  // Adder width for saturating sums that take a bin count.
  localparam int AW    = ((CW > SW) ? CW : SW) + 1;
  // Divider width covers both scaled numerators.
  localparam int NW    = ((8 + CW) > hgq_pkg::CURVE_NUM_W) ? (8 + CW)
                                                            : hgq_pkg::CURVE_NUM_W;
  localparam logic [IW-1:0] LAST_BIN  = IW'(BIN_COUNT - 1);
  localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

  // Configuration registers.
  logic [7:0] bar_scale;
  logic [7:0] curve_scale;

  // Sequencer and histogram state.
  hgq_pkg::state_t state;
  logic [IW-1:0]   clr_idx;
  logic [IW-1:0]   item_idx;
  logic [IW-1:0]   scan_idx;
  logic            pend;
  logic            pend_last;
  logic [CW-1:0]   peak;
  logic [SW-1:0]   total;

  // Query datapath.
  logic [CW-1:0]   cnt;
  logic [SW-1:0]   below;
  logic [SW-1:0]   incl;
  logic [7:0]      bar;
  logic [7:0]      curve;

  // RAM ports.
  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  logic [CW-1:0]   ram_wdata;
  logic [IW-1:0]   ram_raddr;
  logic [CW-1:0]   ram_rdata;

  // Divider ports.
  logic               div_start;
  logic [NW-1:0]      div_num;
  logic [NW-1:0]      div_den;
  hgq_pkg::div_stat_t div_stat;

  logic            accept;
  logic            in_range;
  logic            out_free;
  logic [CW-1:0]   pix_next;
  logic [AW-1:0]   scan_sum;
  logic [SW-1:0]   scan_sat;
  logic [AW-1:0]   incl_sum;
  logic [SW-1:0]   incl_sat;
  logic [NW-1:0]   bar_prod;
  logic [NW-1:0]   curve_prod;
  logic            cfg_write;

  // APB port: zero-wait writes and reads of the two scale registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2:2])
      hgq_pkg::REG_BAR_SCALE:   prdata = {24'd0, bar_scale};
      hgq_pkg::REG_CURVE_SCALE: prdata = {24'd0, curve_scale};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_scale   <= hgq_pkg::BAR_SCALE_RESET;
      curve_scale <= hgq_pkg::CURVE_SCALE_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2:2])
        hgq_pkg::REG_BAR_SCALE:   bar_scale   <= pwdata[7:0];
        hgq_pkg::REG_CURVE_SCALE: curve_scale <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Items are taken only when the sequencer is idle.
  assign req_stall = (state != hgq_pkg::S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign in_range  = (32'(value) < 32'(BIN_COUNT));
  assign out_free  = !rsp_valid || !rsp_stall;

  // The read data of a pixel beat is its bin, in the cycle after acceptance.
  assign pix_next = ram_rdata + 1'b1;

  // Saturating accumulation of the lower bins during the walk.
  assign scan_sum = AW'(below) + AW'(ram_rdata);
  assign scan_sat = (scan_sum > AW'(hgq_pkg::SUM_MAX)) ? hgq_pkg::SUM_MAX
                                                       : scan_sum[SW-1:0];
  assign incl_sum = AW'(below) + AW'(cnt);
  assign incl_sat = (incl_sum > AW'(hgq_pkg::SUM_MAX)) ? hgq_pkg::SUM_MAX
                                                       : incl_sum[SW-1:0];

  // Numerators of the two scaled heights; the divider registers them.
  assign bar_prod   = NW'(bar_scale) * NW'(cnt);
  assign curve_prod = NW'(curve_scale) * NW'(incl);

  // The RAM write port serves the clearing sweep and the pixel write-back;
  // the read port serves pixel lookup and the query walk.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = item_idx;
    ram_wdata = pix_next;
    ram_raddr = scan_idx;
    if (state == hgq_pkg::S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx;
      ram_wdata = '0;
    end else if (state == hgq_pkg::S_PIX) begin
      ram_we    = (ram_rdata != COUNT_MAX);
    end
    if (state == hgq_pkg::S_IDLE) begin
      ram_raddr = IW'(value);
    end
  end

  // The divider is started for the bar, then for the curve, unless the
  // divisor is zero, in which case that height is zero.
  always_comb begin
    div_start = 1'b0;
    div_num   = bar_prod;
    div_den   = NW'(peak);
    if (state == hgq_pkg::S_BAR) begin
      div_start = (peak != '0);
    end else if (state == hgq_pkg::S_CURVE) begin
      div_start = (total != '0);
      div_num   = curve_prod;
      div_den   = NW'(total);
    end
  end

  hgq_ram #(
    .WIDTH (CW),
    .DEPTH (BIN_COUNT)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hgq_div #(
    .NUM_W (NW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat)
  );

  // Read data of the walk: every row below the queried bin adds to the
  // lower sum, and the last row is the queried bin itself.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= (state == hgq_pkg::S_SCAN);
    end
    pend_last <= (scan_idx == item_idx);
    if (pend) begin
      if (pend_last) begin
        cnt <= ram_rdata;
      end else begin
        below <= scan_sat;
      end
    end else if (accept && mode == hgq_pkg::MODE_QUERY) begin
      below <= '0;
      cnt   <= '0;
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hgq_pkg::S_CLEAR;
      clr_idx   <= '0;
      peak      <= '0;
      total     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // In the output state a taken response is replaced below instead.
      if (rsp_valid && !rsp_stall && state != hgq_pkg::S_OUT) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        hgq_pkg::S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_BIN) begin
            state <= hgq_pkg::S_IDLE;
          end
        end
        hgq_pkg::S_IDLE: begin
          if (accept) begin
            item_idx <= IW'(value);
            scan_idx <= '0;
            case (mode)
              hgq_pkg::MODE_CLEAR: begin
                peak    <= '0;
                total   <= '0;
                clr_idx <= '0;
                state   <= hgq_pkg::S_CLEAR;
              end
              hgq_pkg::MODE_PIXEL: begin
                if (in_range) begin
                  state <= hgq_pkg::S_PIX;
                end
              end
              hgq_pkg::MODE_QUERY: begin
                if (in_range) begin
                  state <= hgq_pkg::S_SCAN;
                end else begin
                  // Out-of-range bin: every field of the response is zero.
                  bar   <= '0;
                  curve <= '0;
                  state <= hgq_pkg::S_OUT;
                end
              end
              default: ;
            endcase
          end
        end
        hgq_pkg::S_PIX: begin
          // A saturated bin leaves peak and total untouched.
          if (ram_rdata != COUNT_MAX) begin
            if (pix_next > peak) begin
              peak <= pix_next;
            end
            if (total != hgq_pkg::SUM_MAX) begin
              total <= total + 1'b1;
            end
          end
          state <= hgq_pkg::S_IDLE;
        end
        hgq_pkg::S_SCAN: begin
          if (scan_idx == item_idx) begin
            state <= hgq_pkg::S_SCAN_END;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        hgq_pkg::S_SCAN_END: begin
          // The queried bin's count lands in cnt at this edge.
          state <= hgq_pkg::S_BAR;
        end
        hgq_pkg::S_BAR: begin
          incl <= incl_sat;
          if (peak == '0) begin
            bar   <= '0;
            state <= hgq_pkg::S_CURVE;
          end else begin
            state <= hgq_pkg::S_BAR_WAIT;
          end
        end
        hgq_pkg::S_BAR_WAIT: begin
          if (div_stat.done) begin
            bar   <= div_stat.quot;
            state <= hgq_pkg::S_CURVE;
          end
        end
        hgq_pkg::S_CURVE: begin
          if (total == '0) begin
            curve <= '0;
            state <= hgq_pkg::S_OUT;
          end else begin
            state <= hgq_pkg::S_CURVE_WAIT;
          end
        end
        hgq_pkg::S_CURVE_WAIT: begin
          if (div_stat.done) begin
            curve <= div_stat.quot;
            state <= hgq_pkg::S_OUT;
          end
        end
        hgq_pkg::S_OUT: begin
          // Hand the response to the output register once it is free.
          if (out_free) begin
            rsp_valid    <= 1'b1;
            bin_count    <= 32'(cnt);
            below_sum    <= below;
            bar_height   <= bar;
            curve_height <= curve;
            state        <= hgq_pkg::S_IDLE;
          end
        end
        default: begin
          state <= hgq_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- tb/sv/tb_gray_histogram_with_scaled_query.sv -----
// ----------------------------------------------------------------------------
// Gray histogram with scaled query testbench
// Streams clear, pixel and query beats into the histogram engine. It keeps its
// own bins, peak, total and scale registers, and checks every query response
// field by field. Both channels idle and stall at random, and there are phases
// of long response back-pressure and of a fully steady stream.
// ----------------------------------------------------------------------------
module tb_gray_histogram_with_scaled_query;
  timeunit 1ns;
  timeprecision 1ps;

  // The package names three of the four mode codes. The fourth one is unused
  // and the block must drop it without a response.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int IDLE_PCT      = 23;   // chance of an idle cycle on either side
  localparam int SETTLE_CYCLES = 400;  // longer than a full clear or a worst query
  localparam int HOLD_CYCLES   = 600;  // long response hold-off
  localparam int SHOW_LIMIT    = 10;   // mismatches printed in full

  // One query response as the block should present it.
  typedef struct packed {
    logic [31:0] count;
    logic [39:0] below;
    logic [7:0]  bar;
    logic [7:0]  curve;
  } bin_report_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [1:0]  mode      = hgq_pkg::MODE_CLEAR;
  logic [7:0]  value     = 8'd0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [31:0] bin_count;
  logic [39:0] below_sum;
  logic [7:0]  bar_height;
  logic [7:0]  curve_height;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = 3'd0;
  logic [31:0] pwdata    = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // The testbench's own view of the histogram and the scale registers.
  logic [31:0] hist_bins [256];
  logic [31:0] hist_peak;
  logic [39:0] hist_total;
  logic [7:0]  bar_scale_q;
  logic [7:0]  curve_scale_q;

  // Query responses still owed by the block, oldest first.
  bin_report_t owed_reports [$];

  // Shared controls. idle_on enables random gaps on both channels, and
  // hold_left is a pending response hold-off counted down by the receiver.
  bit          idle_on = 1'b1;
  int          hold_left = 0;
  logic [7:0]  hot_level = 8'd40;

  int n_clear, n_pixel, n_query, n_ignored, n_settings;
  int n_checked, n_mismatch, n_unexpected;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  gray_histogram_with_scaled_query DUT (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .mode         (mode),
    .value        (value),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .bin_count    (bin_count),
    .below_sum    (below_sum),
    .bar_height   (bar_height),
    .curve_height (curve_height),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // --------------------------------------------------------------------------
  // Histogram predictor
  // --------------------------------------------------------------------------

  function automatic void clear_histogram();
    for (int i = 0; i < 256; i++) begin
      hist_bins[i] = 32'd0;
    end
    hist_peak  = 32'd0;
    hist_total = 40'd0;
  endfunction

  // Works out the response for a query on one bin. Running sums saturate at
  // the 40-bit limit, and each height is zero when its divisor is zero.
  function automatic bin_report_t predict_query(input logic [7:0] idx);
    logic [63:0] below;
    logic [63:0] incl;
    logic [63:0] bar;
    logic [63:0] curve;
    bin_report_t r;
    below = 64'd0;
    for (int j = 0; j < idx; j++) begin
      below = below + hist_bins[j];
      if (below > hgq_pkg::SUM_MAX) begin
        below = hgq_pkg::SUM_MAX;
      end
    end
    incl = below + hist_bins[idx];
    if (incl > hgq_pkg::SUM_MAX) begin
      incl = hgq_pkg::SUM_MAX;
    end
    bar   = (hist_peak != 0) ? (64'(bar_scale_q) * hist_bins[idx]) / hist_peak : 64'd0;
    curve = (hist_total != 0) ? (64'(curve_scale_q) * incl) / hist_total : 64'd0;
    if (bar > 64'd255) begin
      bar = 64'd255;
    end
    if (curve > 64'd255) begin
      curve = 64'd255;
    end
    r.count = hist_bins[idx];
    r.below = below[39:0];
    r.bar   = bar[7:0];
    r.curve = curve[7:0];
    return r;
  endfunction

  // Applies one accepted beat to the predicted state. A pixel on a bin that
  // is already full leaves the bin, the peak and the total alone.
  function automatic void account_beat(input logic [1:0] m, input logic [7:0] v);
    case (m)
      hgq_pkg::MODE_CLEAR: begin
        clear_histogram();
        n_clear++;
      end
      hgq_pkg::MODE_PIXEL: begin
        if (hist_bins[v] != 32'hFFFF_FFFF) begin
          hist_bins[v] = hist_bins[v] + 32'd1;
          if (hist_bins[v] > hist_peak) begin
            hist_peak = hist_bins[v];
          end
          if (hist_total != hgq_pkg::SUM_MAX) begin
            hist_total = hist_total + 40'd1;
          end
        end
        n_pixel++;
      end
      hgq_pkg::MODE_QUERY: begin
        owed_reports.push_back(predict_query(v));
        n_query++;
      end
      default: begin
        n_ignored++;
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offers one beat, with an optional random gap first, and returns at the
  // edge where the block takes it. Valid stays high on return so that the
  // next beat can follow without a bubble; any waiting afterwards starts by
  // lowering it.
  task automatic send_beat(input logic [1:0] m, input logic [7:0] v);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      do @(posedge clk); while (idle_on && $urandom_range(99) < IDLE_PCT);
    end
    req_valid <= 1'b1;
    mode      <= m;
    value     <= v;
    do @(posedge clk); while (req_stall);
    account_beat(m, v);
  endtask

  // Draws one random beat. Pixels either land anywhere or pile up near a hot
  // level, so that the peak grows well past one and bar heights spread out.
  // A clear moves the hot level, as a new image would.
  task automatic random_beat(input int query_pct);
    int unsigned pick;
    logic [7:0]  v;
    pick = $urandom_range(999);
    v = ($urandom_range(1) == 1) ? 8'($urandom) : hot_level + 8'($urandom_range(3));
    if (pick < 10) begin
      hot_level = 8'($urandom);
      send_beat(hgq_pkg::MODE_CLEAR, v);
    end else if (pick < 30) begin
      send_beat(MODE_UNUSED, v);
    end else if (pick < 30 + 10 * query_pct) begin
      send_beat(hgq_pkg::MODE_QUERY, v);
    end else begin
      send_beat(hgq_pkg::MODE_PIXEL, v);
    end
  endtask

  // Stops offering beats, waits for every owed response and then lets the
  // block finish any clear or pixel still in progress.
  task automatic drain(input int settle);
    req_valid <= 1'b0;
    while (owed_reports.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------

  task automatic write_scale(input logic [0:0] idx, input logic [7:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == hgq_pkg::REG_BAR_SCALE) begin
      bar_scale_q = val;
    end else begin
      curve_scale_q = val;
    end
  endtask

  // Registers only change while the block is idle.
  task automatic set_scales(input logic [7:0] bar_val, input logic [7:0] curve_val);
    drain(SETTLE_CYCLES);
    write_scale(hgq_pkg::REG_BAR_SCALE, bar_val);
    write_scale(hgq_pkg::REG_CURVE_SCALE, curve_val);
    n_settings++;
  endtask

  // --------------------------------------------------------------------------
  // Response side: takes each beat, checks it against the oldest owed
  // report, and then picks the stall for the next cycle. A requested
  // hold-off takes priority over random stalls.
  // --------------------------------------------------------------------------

  task automatic check_report();
    bin_report_t want;
    bin_report_t got;
    got = '{bin_count, below_sum, bar_height, curve_height};
    if (owed_reports.size() == 0) begin
      if (n_mismatch + n_unexpected < SHOW_LIMIT) begin
        $display("%0t: response with nothing owed: count %0d below %0d bar %0d curve %0d",
                 $realtime, got.count, got.below, got.bar, got.curve);
      end
      n_unexpected++;
    end else begin
      want = owed_reports.pop_front();
      n_checked++;
      if (got.count !== want.count || got.below !== want.below ||
          got.bar !== want.bar || got.curve !== want.curve) begin
        if (n_mismatch + n_unexpected < SHOW_LIMIT) begin
          $display("%0t: response mismatch", $realtime);
          $display("  expected count %0d below %0d bar %0d curve %0d",
                   want.count, want.below, want.bar, want.curve);
          $display("  actual   count %0d below %0d bar %0d curve %0d",
                   got.count, got.below, got.bar, got.curve);
        end
        n_mismatch++;
      end
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        check_report();
      end
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else begin
        rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Queries on an empty histogram give zero heights, since both the peak and
  // the total are zero. The unused mode must be dropped. Pixels then go to
  // the lowest and highest levels and to alternating bit patterns, and a
  // clear brings the zero-divisor case back. A full bin or a full total
  // needs billions of pixels, so those cases live only in the predictor.
  task automatic test_directed_edges();
    send_beat(hgq_pkg::MODE_QUERY, 8'd0);
    send_beat(hgq_pkg::MODE_QUERY, 8'hFF);
    send_beat(MODE_UNUSED, 8'hA5);
    send_beat(MODE_UNUSED, 8'h5A);
    send_beat(hgq_pkg::MODE_PIXEL, 8'd0);
    send_beat(hgq_pkg::MODE_PIXEL, 8'hFF);
    send_beat(hgq_pkg::MODE_PIXEL, 8'hFF);
    send_beat(hgq_pkg::MODE_PIXEL, 8'd128);
    send_beat(hgq_pkg::MODE_PIXEL, 8'd1);
    send_beat(hgq_pkg::MODE_PIXEL, 8'hAA);
    send_beat(hgq_pkg::MODE_PIXEL, 8'h55);
    send_beat(hgq_pkg::MODE_QUERY, 8'd0);
    send_beat(hgq_pkg::MODE_QUERY, 8'd1);
    send_beat(hgq_pkg::MODE_QUERY, 8'd128);
    send_beat(hgq_pkg::MODE_QUERY, 8'hFF);
    send_beat(hgq_pkg::MODE_QUERY, 8'h54);
    send_beat(hgq_pkg::MODE_CLEAR, 8'd0);
    send_beat(hgq_pkg::MODE_QUERY, 8'hFF);
    send_beat(hgq_pkg::MODE_QUERY, 8'd0);
    send_beat(hgq_pkg::MODE_PIXEL, 8'd7);
    send_beat(hgq_pkg::MODE_QUERY, 8'd7);
    send_beat(hgq_pkg::MODE_QUERY, 8'd6);
  endtask

  // Both scales go through zero, full range, one and a middle value, and
  // end back at their reset values. Each setting starts a fresh image.
  task automatic test_scale_settings();
    logic [7:0] bar_set [5]   = '{8'd0, 8'd255, 8'd1, 8'd137, hgq_pkg::BAR_SCALE_RESET};
    logic [7:0] curve_set [5] = '{8'd0, 8'd255, 8'd1, 8'd64, hgq_pkg::CURVE_SCALE_RESET};
    for (int s = 0; s < 5; s++) begin
      set_scales(bar_set[s], curve_set[s]);
      send_beat(hgq_pkg::MODE_CLEAR, 8'($urandom));
      repeat (32) random_beat(25);
    end
  endtask

  task automatic test_random_mix();
    repeat (480) random_beat(15);
  endtask

  // A long stretch with no idling on either side.
  task automatic test_steady_stream();
    idle_on = 1'b0;
    repeat (150) random_beat(15);
    idle_on = 1'b1;
  endtask

  // The receiver holds off for a long time while beats keep coming. Once one
  // response waits in the output register, the next query stalls the input.
  task automatic test_response_hold();
    hold_left = HOLD_CYCLES;
    repeat (80) random_beat(20);
    drain(0);
  endtask

  // The sender waits for each response before going on.
  task automatic test_query_pauses();
    repeat (10) begin
      repeat (5) send_beat(hgq_pkg::MODE_PIXEL, hot_level + 8'($urandom_range(7)));
      send_beat(hgq_pkg::MODE_QUERY, 8'($urandom));
      drain(0);
    end
  endtask

  initial begin
    clear_histogram();
    bar_scale_q   = hgq_pkg::BAR_SCALE_RESET;
    curve_scale_q = hgq_pkg::CURVE_SCALE_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed_edges();
    test_scale_settings();
    test_random_mix();
    test_steady_stream();
    test_response_hold();
    test_query_pauses();
    drain(SETTLE_CYCLES);

    $display("Sent %0d pixel, %0d query, %0d clear and %0d unused-mode beats",
             n_pixel, n_query, n_clear, n_ignored);
    $display("under %0d scale settings; checked %0d responses with random idling,",
             n_settings, n_checked);
    $display("a steady stream and a %0d-cycle hold-off.", HOLD_CYCLES);
    if (n_mismatch == 0 && n_unexpected == 0) begin
      $display("tb_gray_histogram_with_scaled_query OK");
    end else begin
      $display("%0d mismatches, %0d responses with nothing owed", n_mismatch, n_unexpected);
      $display("tb_gray_histogram_with_scaled_query NOT OK");
    end
    $finish;
  end

  // Guard against a hung block. This is several times the slowest legal run.
  initial begin
    #30_000_000;
    $display("Timeout with %0d responses still owed", owed_reports.size());
    $display("tb_gray_histogram_with_scaled_query NOT OK");
    $finish;
  end

endmodule
